// ===== design/sndu_pkg.sv =====
// Shared types and constants for the scatter-update address generator.
// Depends on nothing; every design file imports it.
package sndu_pkg;

    localparam int MAX_DEPTH_DEF    = 4;
    localparam int ADDR_BITS_DEF    = 24;
    localparam int ELEMENT_BITS_DEF = 64;

    localparam int DIM_REGS       = 4;
    localparam int INDEX_BITS     = 64;
    localparam int DIM_BITS       = 16;
    localparam int SLICE_BITS     = 25;
    localparam int DEPTH_REG_BITS = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 25;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_INDEX_DEPTH    = 3'd0,
        REG_SLICE_ELEMENTS = 3'd1,
        REG_DIM_SIZE_0     = 3'd2,
        REG_DIM_SIZE_1     = 3'd3,
        REG_DIM_SIZE_2     = 3'd4,
        REG_DIM_SIZE_3     = 3'd5
    } cfg_reg_t;

    typedef logic [DIM_BITS-1:0] dim_size_t;

endpackage

// ===== design/scatter_nd_update_addresser.sv =====
// Scatter-update address generator: index beats build a flat offset, element beats
// become write commands. Beats pass an input stage, then a result stage; one
// beat/cycle when no stride sweep or output stall holds it. Reset clears phase,
// counters, offset and abort; registers reset to 1. Each config write starts a
// stride sweep (one multiply per cycle) during which at most one beat is taken in
// and held. Depends on sndu_pkg and sndu_stride_gen.
module scatter_nd_update_addresser
    import sndu_pkg::*;
#(
    parameter int MAX_DEPTH    = MAX_DEPTH_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_write_enable,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [INDEX_BITS-1:0]     index_component,
    input  logic [ELEMENT_BITS-1:0]   update_element,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ADDR_BITS-1:0]      write_address,
    output logic [ELEMENT_BITS-1:0]   write_data,
    output logic                      status
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int JW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int PW = ADDR_BITS + DIM_BITS;

    logic [DEPTH_REG_BITS-1:0] index_depth_reg;
    logic [SLICE_BITS-1:0]     slice_elements_reg;
    dim_size_t                 dim_size_reg [DIM_REGS];

    logic                      copy_phase_reg;
    logic [DW-1:0]             comp_cnt_reg;
    logic [SLICE_BITS-1:0]     elem_cnt_reg;
    logic [ADDR_BITS-1:0]      offset_reg;
    logic                      aborted_reg;

    logic                      in_vld_reg;
    logic [INDEX_BITS-1:0]     in_index_reg;
    logic [ELEMENT_BITS-1:0]   in_elem_reg;

    logic                      out_vld_reg;
    logic [ADDR_BITS-1:0]      out_addr_reg;
    logic [ELEMENT_BITS-1:0]   out_data_reg;
    logic                      out_status_reg;

    logic                      sweep_busy;
    logic [ADDR_BITS-1:0]      stride [MAX_DEPTH];

    logic [3:0]                depth_ext;
    logic [DW-1:0]             eff_depth;
    logic [SLICE_BITS-1:0]     eff_slice;
    logic [JW-1:0]             j_sel;
    logic [2:0]                j3;
    dim_size_t                 dim_sel;
    logic                      out_of_range;
    logic [PW-1:0]             prod;
    logic [DW-1:0]             cnt_inc;
    logic [SLICE_BITS-1:0]     elem_inc;
    logic                      produce;
    logic                      consume;

    always_comb
    begin
        depth_ext = {1'b0, index_depth_reg};
        if (depth_ext == 4'd0)
        begin
            eff_depth = DW'(1);
        end
        else if (depth_ext > 4'(MAX_DEPTH))
        begin
            eff_depth = DW'(MAX_DEPTH);
        end
        else
        begin
            eff_depth = DW'(depth_ext);
        end
        eff_slice = (slice_elements_reg == '0) ? SLICE_BITS'(1) : slice_elements_reg;

        j_sel = (comp_cnt_reg > DW'(MAX_DEPTH - 1)) ? JW'(MAX_DEPTH - 1)
                                                     : JW'(comp_cnt_reg);
        j3           = 3'(j_sel);
        dim_sel      = (j3 < 3'(DIM_REGS)) ? dim_size_reg[j3[1:0]] : dim_size_t'(1);
        out_of_range = (|in_index_reg[INDEX_BITS-1:DIM_BITS])
                       || (in_index_reg[DIM_BITS-1:0] >= dim_sel);
        prod         = PW'(in_index_reg[DIM_BITS-1:0]) * PW'(stride[j_sel]);
        cnt_inc      = DW'(j_sel) + DW'(1);
        elem_inc     = elem_cnt_reg + SLICE_BITS'(1);

        produce  = !aborted_reg && (copy_phase_reg || out_of_range);
        consume  = in_vld_reg && !sweep_busy && (!produce || !out_vld_reg || out_ready);
        in_ready = !in_vld_reg || consume;
    end

    sndu_stride_gen #(
        .MAX_DEPTH (MAX_DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DW        (DW),
        .JW        (JW)
    ) u_stride_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_write_enable),
        .depth    (eff_depth),
        .slice    (eff_slice),
        .dim_size (dim_size_reg),
        .busy     (sweep_busy),
        .stride   (stride)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_depth_reg    <= DEPTH_REG_BITS'(1);
            slice_elements_reg <= SLICE_BITS'(1);
            for (int i = 0; i < DIM_REGS; i++)
            begin
                dim_size_reg[i] <= dim_size_t'(1);
            end
        end
        else if (cfg_write_enable)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INDEX_DEPTH:    index_depth_reg    <= cfg_data[DEPTH_REG_BITS-1:0];
                REG_SLICE_ELEMENTS: slice_elements_reg <= cfg_data[SLICE_BITS-1:0];
                REG_DIM_SIZE_0:     dim_size_reg[0]    <= cfg_data[DIM_BITS-1:0];
                REG_DIM_SIZE_1:     dim_size_reg[1]    <= cfg_data[DIM_BITS-1:0];
                REG_DIM_SIZE_2:     dim_size_reg[2]    <= cfg_data[DIM_BITS-1:0];
                REG_DIM_SIZE_3:     dim_size_reg[3]    <= cfg_data[DIM_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_phase_reg <= 1'b0;
            comp_cnt_reg   <= '0;
            elem_cnt_reg   <= '0;
            offset_reg     <= '0;
            aborted_reg    <= 1'b0;
        end
        else if (cfg_write_enable)
        begin
            copy_phase_reg <= 1'b0;
            comp_cnt_reg   <= '0;
            elem_cnt_reg   <= '0;
            offset_reg     <= '0;
            aborted_reg    <= 1'b0;
        end
        else if (consume && !aborted_reg)
        begin
            if (copy_phase_reg)
            begin
                if ((elem_inc >= eff_slice) || (elem_inc == '0))
                begin
                    elem_cnt_reg   <= '0;
                    offset_reg     <= '0;
                    comp_cnt_reg   <= '0;
                    copy_phase_reg <= 1'b0;
                end
                else
                begin
                    elem_cnt_reg <= elem_inc;
                end
            end
            else if (out_of_range)
            begin
                aborted_reg <= 1'b1;
            end
            else
            begin
                offset_reg <= offset_reg + prod[ADDR_BITS-1:0];
                if (cnt_inc >= eff_depth)
                begin
                    comp_cnt_reg   <= '0;
                    elem_cnt_reg   <= '0;
                    copy_phase_reg <= 1'b1;
                end
                else
                begin
                    comp_cnt_reg <= cnt_inc;
                end
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_index_reg <= index_component;
            in_elem_reg  <= update_element;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (consume && produce)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && produce)
        begin
            if (copy_phase_reg)
            begin
                out_addr_reg   <= offset_reg + ADDR_BITS'(elem_cnt_reg);
                out_data_reg   <= in_elem_reg;
                out_status_reg <= 1'b0;
            end
            else
            begin
                out_addr_reg   <= '0;
                out_data_reg   <= '0;
                out_status_reg <= 1'b1;
            end
        end
    end

    assign out_valid     = out_vld_reg;
    assign write_address = out_addr_reg;
    assign write_data    = out_data_reg;
    assign status        = out_status_reg;

    a_abort_sets: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !aborted_reg && !copy_phase_reg && out_of_range && !cfg_write_enable
        |=> aborted_reg)
        else $error("abort not set after out-of-range index");

    a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg && !cfg_write_enable |=> aborted_reg)
        else $error("abort cleared without config write");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_enable |=> !aborted_reg && !copy_phase_reg && offset_reg == '0)
        else $error("config write did not restart");

    a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_status_reg |-> write_address == '0 && write_data == '0)
        else $error("error result carries nonzero payload");

    a_no_work_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(copy_phase_reg) |-> $past(!sweep_busy))
        else $error("slice started during stride sweep");

endmodule

// ===== design/sndu_stride_gen.sv =====
// Stride table generator: one multiply per cycle, sweeping from the last table
// entry down to the first; entries beyond the depth are zeroed. Depends on sndu_pkg.
module sndu_stride_gen
    import sndu_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DW        = $clog2(MAX_DEPTH + 1),
    parameter int JW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DW-1:0]         depth,
    input  logic [SLICE_BITS-1:0] slice,
    input  dim_size_t             dim_size [DIM_REGS],
    output logic                  busy,
    output logic [ADDR_BITS-1:0]  stride [MAX_DEPTH]
);

    localparam int PW = ADDR_BITS + DIM_BITS;

    logic                 busy_reg;
    logic                 first_reg;
    logic [JW-1:0]        k_reg;
    logic [ADDR_BITS-1:0] acc_reg;
    logic [ADDR_BITS-1:0] stride_reg [MAX_DEPTH];

    logic [ADDR_BITS-1:0] acc_cur;
    logic [2:0]           k3;
    dim_size_t            dim_k;
    logic [PW-1:0]        prod;
    logic                 k_used;

    always_comb
    begin
        acc_cur = first_reg ? ADDR_BITS'(slice) : acc_reg;
        k3      = 3'(k_reg);
        dim_k   = (k3 < 3'(DIM_REGS)) ? dim_size[k3[1:0]] : dim_size_t'(1);
        prod    = PW'(acc_cur) * PW'(dim_k);
        k_used  = 4'(k_reg) < 4'(depth);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            k_reg     <= '0;
            acc_reg   <= '0;
            for (int i = 0; i < MAX_DEPTH; i++)
            begin
                stride_reg[i] <= (i == 0) ? ADDR_BITS'(1) : '0;
            end
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            first_reg <= 1'b1;
            k_reg     <= JW'(MAX_DEPTH - 1);
        end
        else if (busy_reg)
        begin
            first_reg         <= 1'b0;
            stride_reg[k_reg] <= k_used ? acc_cur : '0;
            acc_reg           <= k_used ? prod[ADDR_BITS-1:0] : acc_cur;
            if (k_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                k_reg <= k_reg - JW'(1);
            end
        end
    end

    assign busy   = busy_reg;
    assign stride = stride_reg;

endmodule

// ===== tb/tb_sndu_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard package for the scatter-update address generator bench: a beat-level
// model of the addresser plus the queue of write commands it still owes.
// Depends on sndu_pkg.
package sndu_tb_pkg;
    import sndu_pkg::*;

    localparam logic STATUS_WRITE       = 1'b0;
    localparam logic STATUS_RANGE_ERROR = 1'b1;
    localparam int   MAX_REPORTS        = 10;

    typedef logic [ADDR_BITS_DEF-1:0]    addr_t;
    typedef logic [ELEMENT_BITS_DEF-1:0] elem_t;

    typedef struct {
        addr_t address;
        elem_t data;
        logic  status;
    } write_cmd_t;

    class write_cmd_scoreboard;
        logic [DEPTH_REG_BITS-1:0] depth_reg;
        logic [SLICE_BITS-1:0]     slice_reg;
        dim_size_t                 dim_reg[DIM_REGS];
        addr_t                     stride[MAX_DEPTH_DEF];
        bit                        in_copy;
        bit                        halted;
        int unsigned               comp_idx;
        logic [SLICE_BITS-1:0]     elem_idx;
        addr_t                     offset;
        write_cmd_t                owed_writes[$];
        int unsigned               mismatches;
        int unsigned               beats_taken;
        int unsigned               results_seen;
        int unsigned               range_errors;
        int unsigned               reg_writes;

        function new();
            int k;
            depth_reg = DEPTH_REG_BITS'(1);
            slice_reg = SLICE_BITS'(1);
            for (k = 0; k < DIM_REGS; k++)
                dim_reg[k] = dim_size_t'(1);
            mismatches   = 0;
            beats_taken  = 0;
            results_seen = 0;
            range_errors = 0;
            reg_writes   = 0;
            restart();
        endfunction

        static function int unsigned depth_used(logic [DEPTH_REG_BITS-1:0] d);
            if (d == 0)
                return 1;
            if (d > MAX_DEPTH_DEF)
                return MAX_DEPTH_DEF;
            return 32'(d);
        endfunction

        static function int unsigned slice_used(logic [SLICE_BITS-1:0] s);
            return (s == '0) ? 1 : 32'(s);
        endfunction

        function void restart();
            addr_t       acc;
            int unsigned depth;
            int          j;
            depth = depth_used(depth_reg);
            acc   = addr_t'(slice_used(slice_reg));
            for (j = MAX_DEPTH_DEF - 1; j >= 0; j--)
            begin
                if (j < depth)
                begin
                    stride[j] = acc;
                    acc = acc * dim_reg[j];
                end
                else
                    stride[j] = '0;
            end
            in_copy  = 1'b0;
            halted   = 1'b0;
            comp_idx = 0;
            elem_idx = '0;
            offset   = '0;
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_INDEX_DEPTH:    depth_reg = value[DEPTH_REG_BITS-1:0];
                REG_SLICE_ELEMENTS: slice_reg = value[SLICE_BITS-1:0];
                REG_DIM_SIZE_0, REG_DIM_SIZE_1, REG_DIM_SIZE_2, REG_DIM_SIZE_3:
                    dim_reg[idx - REG_DIM_SIZE_0] = value[DIM_BITS-1:0];
                default: ;
            endcase
            reg_writes++;
            restart();
        endfunction

        function void note_beat(logic [INDEX_BITS-1:0] index_value, elem_t element);
            write_cmd_t cmd;
            beats_taken++;
            if (halted)
                return;
            if (!in_copy)
            begin
                if (index_value[INDEX_BITS-1] || index_value >= dim_reg[comp_idx])
                begin
                    halted      = 1'b1;
                    cmd.address = '0;
                    cmd.data    = '0;
                    cmd.status  = STATUS_RANGE_ERROR;
                    owed_writes = {owed_writes, cmd};
                    range_errors++;
                    return;
                end
                offset = offset + addr_t'(index_value) * stride[comp_idx];
                comp_idx++;
                if (comp_idx >= depth_used(depth_reg))
                begin
                    comp_idx = 0;
                    elem_idx = '0;
                    in_copy  = 1'b1;
                end
                return;
            end
            cmd.address = offset + addr_t'(elem_idx);
            cmd.data    = element;
            cmd.status  = STATUS_WRITE;
            owed_writes = {owed_writes, cmd};
            elem_idx = elem_idx + 1'b1;
            if (elem_idx >= slice_used(slice_reg) || elem_idx == 0)
            begin
                elem_idx = '0;
                offset   = '0;
                comp_idx = 0;
                in_copy  = 1'b0;
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_write(addr_t address, elem_t data, logic status);
            write_cmd_t want;
            results_seen++;
            if (owed_writes.size() == 0)
            begin
                flag($sformatf("unexpected result addr %h data %h status %b",
                               address, data, status));
                return;
            end
            want = owed_writes.pop_front();
            if (want.address !== address || want.data !== data || want.status !== status)
                flag($sformatf({"expected addr %h data %h status %b, ",
                                "got addr %h data %h status %b"},
                               want.address, want.data, want.status, address, data, status));
        endfunction

        function void close_out();
            if (owed_writes.size() != 0)
                flag($sformatf("%0d expected results never arrived", owed_writes.size()));
        endfunction
    endclass

endpackage

// ===== tb/tb_scatter_nd_update_addresser.sv =====
`timescale 1ns / 100ps
// Top-level bench for scatter_nd_update_addresser: directed corner slices, then
// randomized register settings and slice streams with random stalls on both sides.
// Depends on sndu_pkg, sndu_tb_pkg and the design.
module tb_scatter_nd_update_addresser;
    import sndu_pkg::*;
    import sndu_tb_pkg::*;

    localparam int          CLK_HALF      = 4;
    localparam int          TARGET_BEATS  = 2000;
    localparam int          MAX_GAP       = 13;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int unsigned HOLD_AT_WRITE = 400;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          TIMEOUT_NS    = 5_000_000;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 3'd7;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write_enable;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [INDEX_BITS-1:0]       index_component;
    logic [ELEMENT_BITS_DEF-1:0] update_element;
    logic                        out_valid;
    logic                        out_ready;
    logic [ADDR_BITS_DEF-1:0]    write_address;
    logic [ELEMENT_BITS_DEF-1:0] write_data;
    logic                        status;

    write_cmd_scoreboard sb;
    int unsigned         counted_beats;
    int unsigned         writes_taken;
    bit                  send_calm;
    bit                  recv_calm;
    bit                  hold_done;

    scatter_nd_update_addresser u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .index_component  (index_component),
        .update_element   (update_element),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .write_address    (write_address),
        .write_data       (write_data),
        .status           (status)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_enable)
                sb.write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_beat(index_component, update_element);
            if (out_valid && out_ready)
                sb.check_write(write_address, write_data, status);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic send_beat(input logic [INDEX_BITS-1:0] index_value,
                             input logic [ELEMENT_BITS_DEF-1:0] element);
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        index_component <= index_value;
        update_element  <= element;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
    endtask

    // drop valid, wait for every owed result, then let index beats drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_slice(input int unsigned depth_eff, input int unsigned slice_eff,
                             input dim_size_t dims[DIM_REGS], input int err_at,
                             input int unsigned keep, output bit hit_error);
        int unsigned           sent;
        int                    j;
        int unsigned           e;
        logic [INDEX_BITS-1:0] value;
        hit_error = 1'b0;
        sent      = 0;
        for (j = 0; j < depth_eff && sent < keep; j++)
        begin
            if (j == err_at || dims[j] == 0)
            begin
                case ($urandom_range(0, 3))
                    0: value = 64'h8000_0000_0000_0000 | rand64();
                    1: value = 64'(dims[j]) + $urandom_range(0, 3);
                    2: value = (rand64() & 64'h7FFF_FFFF_FFFF_FFFF)
                               | (64'd1 << $urandom_range(16, 62));
                    default: value = $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                          : 64'h8000_0000_0000_0000;
                endcase
                hit_error = 1'b1;
            end
            else
                value = 64'($urandom_range(0, dims[j] - 1));
            send_beat(value, rand64());
            sent++;
            counted_beats++;
            if (hit_error)
                return;
        end
        for (e = 0; e < slice_eff && sent < keep; e++)
        begin
            send_beat(rand64(), rand64());
            sent++;
            counted_beats++;
        end
    endtask

    initial
    begin
        out_ready    = 1'b0;
        writes_taken = 0;
        recv_calm    = 1'b0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int unsigned gap;
            if (!hold_done && writes_taken >= HOLD_AT_WRITE && in_valid)
            begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
                gap = draw_gap(recv_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            writes_taken++;
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("timeout after %0d results", writes_taken);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [DEPTH_REG_BITS-1:0] depth_r;
        logic [SLICE_BITS-1:0]     slice_r;
        dim_size_t                 dims_r[DIM_REGS];
        int unsigned               depth_eff;
        int unsigned               slice_eff;
        int unsigned               slices;
        int unsigned               s;
        int unsigned               keep;
        int unsigned               k;
        int                        err_at;
        bit                        hit_error;

        sb               = new();
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = REG_INDEX_DEPTH;
        cfg_data         = '0;
        in_valid         = 1'b0;
        index_component  = '0;
        update_element   = '0;
        counted_beats    = 0;
        send_calm        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one index, one element
        send_beat(64'd0, rand64());
        send_beat(rand64(), 64'hFFFF_FFFF_FFFF_FFFF);

        // zero depth, widest slice register, largest first dimension
        settle();
        write_register(REG_INDEX_DEPTH, 25'd0);
        write_register(REG_SLICE_ELEMENTS, 25'h1FF_FFFF);
        write_register(REG_DIM_SIZE_0, 25'd65535);
        send_beat(64'd65534, rand64());
        send_beat(rand64(), 64'd0);
        send_beat(rand64(), rand64());

        // depth above the limit, zero slice, strides wrapping the address space
        settle();
        write_register(REG_INDEX_DEPTH, 25'd7);
        write_register(REG_SLICE_ELEMENTS, 25'd0);
        write_register(REG_DIM_SIZE_1, 25'd65535);
        write_register(REG_DIM_SIZE_2, 25'd65535);
        write_register(REG_DIM_SIZE_3, 25'd65535);
        send_beat(64'd65534, rand64());
        send_beat(64'd0, rand64());
        send_beat(64'd65534, rand64());
        send_beat(64'd1, rand64());
        send_beat(rand64(), rand64());

        // zero-size dimension aborts; later beats are dropped
        settle();
        write_register(REG_INDEX_DEPTH, 25'd2);
        write_register(REG_SLICE_ELEMENTS, 25'h100_0000);
        write_register(REG_DIM_SIZE_0, 25'd3);
        write_register(REG_DIM_SIZE_1, 25'd0);
        send_beat(64'd2, rand64());
        send_beat(64'd0, rand64());
        send_beat(rand64(), rand64());

        // negative index aborts
        settle();
        write_register(REG_DIM_SIZE_1, 25'd7);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, rand64());
        send_beat(rand64(), rand64());

        // write to an unused index clears the abort
        settle();
        write_register(CFG_SPARE_INDEX, 25'd0);
        send_beat(64'd1, rand64());
        send_beat(64'd6, rand64());
        send_beat(rand64(), rand64());
        send_beat(rand64(), rand64());

        // largest positive index is out of range
        settle();
        write_register(REG_INDEX_DEPTH, 25'd1);
        write_register(REG_DIM_SIZE_0, 25'd1);
        send_beat(64'h7FFF_FFFF_FFFF_FFFF, rand64());

        while (counted_beats < TARGET_BEATS)
        begin
            depth_r = DEPTH_REG_BITS'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       slice_r = '0;
                1:       slice_r = SLICE_BITS'($urandom_range(7, 40));
                default: slice_r = SLICE_BITS'($urandom_range(1, 6));
            endcase
            for (k = 0; k < DIM_REGS; k++)
            begin
                case ($urandom_range(0, 19))
                    0:       dims_r[k] = '0;
                    1:       dims_r[k] = 16'hFFFF;
                    2, 3:    dims_r[k] = dim_size_t'($urandom_range(1, 65535));
                    default: dims_r[k] = dim_size_t'($urandom_range(1, 12));
                endcase
            end
            settle();
            write_register(REG_INDEX_DEPTH, CFG_DATA_BITS'(depth_r));
            write_register(REG_SLICE_ELEMENTS, slice_r);
            for (k = 0; k < DIM_REGS; k++)
                write_register(CFG_INDEX_BITS'(REG_DIM_SIZE_0 + k),
                               CFG_DATA_BITS'(dims_r[k]));
            depth_eff = write_cmd_scoreboard::depth_used(depth_r);
            slice_eff = write_cmd_scoreboard::slice_used(slice_r);
            slices    = $urandom_range(1, 8);
            for (s = 0; s < slices; s++)
            begin
                err_at = ($urandom_range(0, 29) == 0) ? int'($urandom_range(0, depth_eff - 1))
                                                      : -1;
                keep = depth_eff + slice_eff;
                if (s == slices - 1 && $urandom_range(0, 7) == 0)
                    keep = $urandom_range(1, depth_eff + slice_eff);
                run_slice(depth_eff, slice_eff, dims_r, err_at, keep, hit_error);
                if (hit_error)
                begin
                    repeat ($urandom_range(0, 3)) send_beat(rand64(), rand64());
                    break;
                end
            end
        end

        settle();
        sb.close_out();
        $display("covered %0d input beats, %0d results, %0d range aborts",
                 sb.beats_taken, sb.results_seen, sb.range_errors);
        $display("%0d register writes over random and corner settings, %0d-cycle output hold",
                 sb.reg_writes, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
